// File: hdl/cpp_pkg.sv
// cpp_pkg: types, stage numbering and fixed-point helpers for camera_point_projection.
// No dependencies.
package cpp_pkg;

    localparam int DIV_BITS = 56;
    localparam int S_NORM   = DIV_BITS + 1;
    localparam int S_D1     = S_NORM + 1;
    localparam int S_PIX    = S_D1 + 8;
    localparam int NSTG     = S_PIX + 1;

    localparam logic [2:0] REG_FOCAL = 3'd0;
    localparam logic [2:0] REG_PP    = 3'd1;
    localparam logic [2:0] REG_K1    = 3'd2;
    localparam logic [2:0] REG_K2    = 3'd3;
    localparam logic [2:0] REG_K3    = 3'd4;
    localparam logic [2:0] REG_P1    = 3'd5;
    localparam logic [2:0] REG_P2    = 3'd6;
    localparam logic [2:0] REG_MODE  = 3'd7;

    localparam logic [1:0] MODE_BROWN = 2'd1;
    localparam logic [63:0] FOCAL_RESET = 64'h0001_0000_0001_0000;
    localparam logic signed [65:0] Q24_ONE = 66'sd16777216;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } cpp_in_t;

    typedef struct packed {
        logic signed [31:0] pixel_u;
        logic signed [31:0] pixel_v;
        logic               valid_res;
        logic               saturated;
    } cpp_out_t;

    typedef struct packed {
        logic                  vld;
        logic                  ok;
        logic                  neg_x;
        logic                  neg_y;
        logic [30:0]           zmag;
        logic [30:0]           rem_x;
        logic [30:0]           rem_y;
        logic [DIV_BITS-1:0]   dq_x;
        logic [DIV_BITS-1:0]   dq_y;
        logic                  nsat;
        logic                  dsat;
        logic signed [31:0]    x;
        logic signed [31:0]    y;
        logic signed [31:0]    x2;
        logic signed [31:0]    y2;
        logic signed [31:0]    two_xy;
        logic signed [31:0]    r2;
        logic signed [31:0]    r4;
        logic signed [31:0]    r6;
        logic signed [31:0]    k1r2;
        logic signed [31:0]    k2r4;
        logic signed [31:0]    k3r6;
        logic signed [31:0]    tx;
        logic signed [31:0]    ty;
        logic signed [31:0]    radial;
        logic signed [31:0]    ax;
        logic signed [31:0]    bx;
        logic signed [31:0]    cxp;
        logic signed [31:0]    ay;
        logic signed [31:0]    by;
        logic signed [31:0]    cyp;
        logic signed [31:0]    xd;
        logic signed [31:0]    yd;
        cpp_out_t              res;
    } cpp_stage_t;

    // clamp to signed 32 bits; bit 32 flags a clamp
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return {1'b1, 32'h7FFF_FFFF};
        else if (v < -66'sd2147483648)
            return {1'b1, 32'h8000_0000};
        else
            return {1'b0, v[31:0]};
    endfunction

    // Q8.24 product, floored and clamped
    function automatic logic [32:0] mulq(input logic signed [31:0] a,
                                         input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return sat32(66'(p >>> 24));
    endfunction

endpackage

// File: hdl/camera_point_projection.sv
// camera_point_projection: pinhole projection with Brown-Conrady distortion, fully pipelined.
// Depends on cpp_pkg.
//
//   channel | handshake         | payload
//   input   | in_valid/in_stall | in_data  (point_x, point_y, point_z)
//   output  | out_valid/out_stall | out_data (pixel_u, pixel_v, valid_res, saturated)
//   config  | cfg_we            | cfg_index, cfg_data
//
// One point per cycle while no valid output is stalled; a capture stage, 56 restoring-divider
// stages (one quotient bit each), a normalise stage, eight distortion stages and a pixel stage.
// A stall on a valid output freezes the whole pipeline; nothing is lost or repeated.
// Reset clears the valid bits and loads the register reset values.
module camera_point_projection (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  cpp_pkg::cpp_in_t  in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output cpp_pkg::cpp_out_t out_data,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [63:0]     cfg_data
);
    import cpp_pkg::*;

    logic [63:0]        focal_reg;
    logic [63:0]        pp_reg;
    logic signed [31:0] k1_reg, k2_reg, k3_reg, p1_reg, p2_reg;
    logic [1:0]         mode_reg;

    cpp_stage_t stg_reg  [0:NSTG-1];
    cpp_stage_t stg_next [0:NSTG-1];
    logic       adv;

    assign adv       = !(stg_reg[NSTG-1].vld && out_stall);
    assign in_stall  = !adv;
    assign out_valid = stg_reg[NSTG-1].vld;
    assign out_data  = stg_reg[NSTG-1].res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg <= FOCAL_RESET;
            pp_reg    <= '0;
            k1_reg    <= '0;
            k2_reg    <= '0;
            k3_reg    <= '0;
            p1_reg    <= '0;
            p2_reg    <= '0;
            mode_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FOCAL: focal_reg <= cfg_data;
                REG_PP:    pp_reg    <= cfg_data;
                REG_K1:    k1_reg    <= cfg_data[31:0];
                REG_K2:    k2_reg    <= cfg_data[31:0];
                REG_K3:    k3_reg    <= cfg_data[31:0];
                REG_P1:    p1_reg    <= cfg_data[31:0];
                REG_P2:    p2_reg    <= cfg_data[31:0];
                REG_MODE:  mode_reg  <= cfg_data[1:0];
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    // capture
    always_comb
    begin
        stg_next[0]       = '0;
        stg_next[0].vld   = in_valid;
        stg_next[0].ok    = (in_data.point_z > 32'sd0);
        stg_next[0].neg_x = in_data.point_x[31];
        stg_next[0].neg_y = in_data.point_y[31];
        stg_next[0].zmag  = in_data.point_z[30:0];
        stg_next[0].dq_x  = {(in_data.point_x[31] ? 32'(-in_data.point_x)
                                                  : 32'(in_data.point_x)), 24'd0};
        stg_next[0].dq_y  = {(in_data.point_y[31] ? 32'(-in_data.point_y)
                                                  : 32'(in_data.point_y)), 24'd0};
    end

    // one quotient bit per stage
    for (genvar g = 0; g < DIV_BITS; g++)
    begin : g_div
        logic [31:0] shx, shy;
        always_comb
        begin
            stg_next[g+1] = stg_reg[g];
            shx = {stg_reg[g].rem_x, stg_reg[g].dq_x[DIV_BITS-1]};
            shy = {stg_reg[g].rem_y, stg_reg[g].dq_y[DIV_BITS-1]};
            if (shx >= {1'b0, stg_reg[g].zmag})
            begin
                stg_next[g+1].rem_x = 31'(shx - {1'b0, stg_reg[g].zmag});
                stg_next[g+1].dq_x  = {stg_reg[g].dq_x[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                stg_next[g+1].rem_x = shx[30:0];
                stg_next[g+1].dq_x  = {stg_reg[g].dq_x[DIV_BITS-2:0], 1'b0};
            end
            if (shy >= {1'b0, stg_reg[g].zmag})
            begin
                stg_next[g+1].rem_y = 31'(shy - {1'b0, stg_reg[g].zmag});
                stg_next[g+1].dq_y  = {stg_reg[g].dq_y[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                stg_next[g+1].rem_y = shy[30:0];
                stg_next[g+1].dq_y  = {stg_reg[g].dq_y[DIV_BITS-2:0], 1'b0};
            end
        end
    end

    // apply sign and clamp quotients
    always_comb
    begin
        logic [32:0] tx_s, ty_s;
        cpp_stage_t  p;
        p    = stg_reg[S_NORM-1];
        tx_s = sat32(p.neg_x ? -$signed({10'd0, p.dq_x}) : $signed({10'd0, p.dq_x}));
        ty_s = sat32(p.neg_y ? -$signed({10'd0, p.dq_y}) : $signed({10'd0, p.dq_y}));
        stg_next[S_NORM]      = p;
        stg_next[S_NORM].x    = tx_s[31:0];
        stg_next[S_NORM].y    = ty_s[31:0];
        stg_next[S_NORM].nsat = tx_s[32] | ty_s[32];
    end

    // distortion: squares and cross term
    always_comb
    begin
        logic [32:0] a, b, c, d;
        cpp_stage_t  p;
        p = stg_reg[S_D1-1];
        a = mulq(p.x, p.x);
        b = mulq(p.y, p.y);
        c = mulq(p.x, p.y);
        d = sat32(66'($signed(c[31:0])) <<< 1);
        stg_next[S_D1]        = p;
        stg_next[S_D1].x2     = a[31:0];
        stg_next[S_D1].y2     = b[31:0];
        stg_next[S_D1].two_xy = d[31:0];
        stg_next[S_D1].dsat   = a[32] | b[32] | c[32] | d[32];
    end

    // r2
    always_comb
    begin
        logic [32:0] a;
        cpp_stage_t  p;
        p = stg_reg[S_D1];
        a = sat32(66'(p.x2) + 66'(p.y2));
        stg_next[S_D1+1]      = p;
        stg_next[S_D1+1].r2   = a[31:0];
        stg_next[S_D1+1].dsat = p.dsat | a[32];
    end

    // r4, k1 r2, tangential sums
    always_comb
    begin
        logic [32:0] a, b, c, d;
        cpp_stage_t  p;
        p = stg_reg[S_D1+1];
        a = mulq(p.r2, p.r2);
        b = mulq(k1_reg, p.r2);
        c = sat32(66'(p.r2) + (66'(p.x2) <<< 1));
        d = sat32(66'(p.r2) + (66'(p.y2) <<< 1));
        stg_next[S_D1+2]      = p;
        stg_next[S_D1+2].r4   = a[31:0];
        stg_next[S_D1+2].k1r2 = b[31:0];
        stg_next[S_D1+2].tx   = c[31:0];
        stg_next[S_D1+2].ty   = d[31:0];
        stg_next[S_D1+2].dsat = p.dsat | a[32] | b[32] | c[32] | d[32];
    end

    // r6, k2 r4
    always_comb
    begin
        logic [32:0] a, b;
        cpp_stage_t  p;
        p = stg_reg[S_D1+2];
        a = mulq(p.r4, p.r2);
        b = mulq(k2_reg, p.r4);
        stg_next[S_D1+3]      = p;
        stg_next[S_D1+3].r6   = a[31:0];
        stg_next[S_D1+3].k2r4 = b[31:0];
        stg_next[S_D1+3].dsat = p.dsat | a[32] | b[32];
    end

    // k3 r6
    always_comb
    begin
        logic [32:0] a;
        cpp_stage_t  p;
        p = stg_reg[S_D1+3];
        a = mulq(k3_reg, p.r6);
        stg_next[S_D1+4]      = p;
        stg_next[S_D1+4].k3r6 = a[31:0];
        stg_next[S_D1+4].dsat = p.dsat | a[32];
    end

    // radial factor
    always_comb
    begin
        logic [32:0] a;
        cpp_stage_t  p;
        p = stg_reg[S_D1+4];
        a = sat32(Q24_ONE + 66'(p.k1r2) + 66'(p.k2r4) + 66'(p.k3r6));
        stg_next[S_D1+5]        = p;
        stg_next[S_D1+5].radial = a[31:0];
        stg_next[S_D1+5].dsat   = p.dsat | a[32];
    end

    // distortion products
    always_comb
    begin
        logic [32:0] a, b, c, d, e, f;
        cpp_stage_t  p;
        p = stg_reg[S_D1+5];
        a = mulq(p.x, p.radial);
        b = mulq(p1_reg, p.two_xy);
        c = mulq(p2_reg, p.tx);
        d = mulq(p.y, p.radial);
        e = mulq(p1_reg, p.ty);
        f = mulq(p2_reg, p.two_xy);
        stg_next[S_D1+6]      = p;
        stg_next[S_D1+6].ax   = a[31:0];
        stg_next[S_D1+6].bx   = b[31:0];
        stg_next[S_D1+6].cxp  = c[31:0];
        stg_next[S_D1+6].ay   = d[31:0];
        stg_next[S_D1+6].by   = e[31:0];
        stg_next[S_D1+6].cyp  = f[31:0];
        stg_next[S_D1+6].dsat = p.dsat | a[32] | b[32] | c[32] | d[32] | e[32] | f[32];
    end

    // distorted coordinates, or bypass
    always_comb
    begin
        logic [32:0] a, b;
        cpp_stage_t  p;
        p = stg_reg[S_D1+6];
        a = sat32(66'(p.ax) + 66'(p.bx) + 66'(p.cxp));
        b = sat32(66'(p.ay) + 66'(p.by) + 66'(p.cyp));
        stg_next[S_D1+7] = p;
        if (mode_reg == MODE_BROWN)
        begin
            stg_next[S_D1+7].xd   = a[31:0];
            stg_next[S_D1+7].yd   = b[31:0];
            stg_next[S_D1+7].dsat = p.dsat | a[32] | b[32];
        end
        else
        begin
            stg_next[S_D1+7].xd   = p.x;
            stg_next[S_D1+7].yd   = p.y;
            stg_next[S_D1+7].dsat = 1'b0;
        end
    end

    // focal scale and principal point
    always_comb
    begin
        logic signed [32:0] fxs, fys;
        logic signed [64:0] pu, pv;
        logic [32:0]        a, b;
        cpp_stage_t         p;
        p   = stg_reg[S_PIX-1];
        fxs = $signed({1'b0, focal_reg[31:0]});
        fys = $signed({1'b0, focal_reg[63:32]});
        pu  = fxs * p.xd;
        pv  = fys * p.yd;
        a   = sat32(66'(pu >>> 24) + 66'($signed(pp_reg[31:0])));
        b   = sat32(66'(pv >>> 24) + 66'($signed(pp_reg[63:32])));
        stg_next[S_PIX] = p;
        if (p.ok)
        begin
            stg_next[S_PIX].res.pixel_u   = a[31:0];
            stg_next[S_PIX].res.pixel_v   = b[31:0];
            stg_next[S_PIX].res.valid_res = 1'b1;
            stg_next[S_PIX].res.saturated = p.nsat | p.dsat | a[32] | b[32];
        end
        else
        begin
            stg_next[S_PIX].res = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                stg_reg[i] <= '0;
            end
        end
        else if (adv)
        begin
            for (int i = 0; i < NSTG; i++)
            begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

endmodule

// File: hdl/cpp_checker.sv
// cpp_checker: port-level checks for camera_point_projection, bound to the top level.
// Depends on cpp_pkg.
module cpp_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input cpp_pkg::cpp_out_t out_data
);
    import cpp_pkg::*;

    // hold a stalled transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed under stall");

    // drop to zero for non-positive depth
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.valid_res |->
            out_data.pixel_u == 32'sd0 && out_data.pixel_v == 32'sd0
            && !out_data.saturated)
        else $error("invalid result not zero");

    // advance whenever the output side can take a transfer
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall not tied to output stall");

endmodule

bind camera_point_projection cpp_checker u_cpp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
